[rtl/lct_pkg.sv]
package lct_pkg;

	localparam int MAX_ENTRIES_DEF = 16;
	localparam int KEY_W           = 32;
	localparam int CAP_W           = 5;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	// Output kind codes carried on m_axis_tuser.
	localparam logic KIND_STATUS = 1'b0;
	localparam logic KIND_ENTRY  = 1'b1;

	// Per-cycle command broadcast to every cell of the key chain.
	typedef struct packed {
		logic access;  // an access is accepted this cycle
		logic evict;   // the access is a miss that drops the least recent key
		logic dump;    // whole chain shifts one cell toward the head
	} cell_ctl_t;

endpackage

[rtl/lct_cell.sv]
module lct_cell #(
	parameter int IDX   = 0,
	parameter int OCC_W = 5
) (
	input  logic                        clk,
	input  lct_pkg::cell_ctl_t          ctl,
	input  logic [lct_pkg::KEY_W-1:0]   key,
	input  logic [OCC_W-1:0]            occ,
	input  logic [OCC_W-1:0]            top,
	input  logic [lct_pkg::KEY_W-1:0]   next_key,
	input  logic                        pref_in,
	output logic                        pref_out,
	output logic                        match,
	output logic [lct_pkg::KEY_W-1:0]   key_out
);

	logic [lct_pkg::KEY_W-1:0] key_q;
	logic                      valid;
	logic                      sel;
	logic                      is_top;

	assign valid   = OCC_W'(IDX) < occ;
	assign match   = valid && (key_q == key);
	assign is_top  = OCC_W'(IDX) == top;
	// The removed slot is the matching cell, or the head cell on an eviction.
	// Every cell from there up to the write slot takes its upper neighbor.
	assign sel      = match || (ctl.evict && (IDX == 0));
	assign pref_out = pref_in || sel;
	assign key_out  = key_q;

	always_ff @(posedge clk) begin
		if (ctl.dump) begin
			key_q <= next_key;
		end else if (ctl.access) begin
			if (is_top) begin
				key_q <= key;
			end else if (pref_out && (OCC_W'(IDX) < top)) begin
				key_q <= next_key;
			end
		end
	end

endmodule

[rtl/lru_cache_tracker.sv]
// LRU key tracker built as a chain of MAX_ENTRIES cells, cell 0 holding the least recent
// key. Every access gives one status transfer (tuser 0) with hit, eviction flag and
// evicted key; an access with s_axis_tlast set is followed by one entry transfer
// (tuser 1) per stored key, least recent first, after which the store is empty.
// Accesses without tlast are taken one per clock as long as m_axis_tready keeps the
// output register draining: all cells compare the key in parallel and shift in the
// same cycle, so the key compare plus the match prefix ripple along the chain sets
// the clock. An access with tlast blocks new accesses while the dump shifts the
// chain out through cell 0, one cell per cycle as long as the output drains.
// The capacity register is written through cfg_wr_en/cfg_wr_data; 0 acts as 1
// and values above MAX_ENTRIES act as MAX_ENTRIES.
module lru_cache_tracker #(
	parameter int MAX_ENTRIES = lct_pkg::MAX_ENTRIES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [lct_pkg::CAP_W-1:0]   cfg_wr_data,    // capacity
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [31:0]                 s_axis_tdata,   // key
	input  logic                        s_axis_tlast,   // end_of_sequence
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	// hit [0], evicted_valid [1], evicted_key [33:2], entry_key [65:34], zero pad
	output logic [71:0]                 m_axis_tdata,
	output logic                        m_axis_tuser,   // kind
	output logic                        m_axis_tlast    // last
);

	localparam int KW    = lct_pkg::KEY_W;
	localparam int OCC_W = $clog2(MAX_ENTRIES + 1);
	localparam int CMP_W = (OCC_W > lct_pkg::CAP_W) ? OCC_W : lct_pkg::CAP_W;

	typedef enum logic {ST_IDLE, ST_DUMP} state_t;

	state_t                    state_q;
	logic [lct_pkg::CAP_W-1:0] cap_q;
	logic [OCC_W-1:0]          occ_q;
	logic                      out_valid_q;
	logic                      out_kind_q;
	logic                      out_hit_q;
	logic                      out_ev_q;
	logic [KW-1:0]             out_evkey_q;
	logic [KW-1:0]             out_entry_q;
	logic                      out_last_q;

	logic [KW-1:0]             chain_key [MAX_ENTRIES+1];
	logic [MAX_ENTRIES:0]      pref;
	logic [MAX_ENTRIES-1:0]    match;
	lct_pkg::cell_ctl_t        ctl;

	logic                      out_free;
	logic                      fire;
	logic                      hit;
	logic                      evict;
	logic [CMP_W-1:0]          cap_w;
	logic [CMP_W-1:0]          eff_cap;
	logic [OCC_W-1:0]          top_idx;
	logic                      dump_step;

	assign out_free      = !out_valid_q || m_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE) && out_free;
	assign fire          = s_axis_tvalid && s_axis_tready;
	assign dump_step     = (state_q == ST_DUMP) && out_free;

	assign cap_w = CMP_W'(cap_q);
	always_comb begin
		if (cap_q == '0) begin
			eff_cap = CMP_W'(1);
		end else if (cap_w > CMP_W'(MAX_ENTRIES)) begin
			eff_cap = CMP_W'(MAX_ENTRIES);
		end else begin
			eff_cap = cap_w;
		end
	end

	assign hit     = |match;
	assign evict   = !hit && (CMP_W'(occ_q) >= eff_cap);
	assign top_idx = (hit || evict) ? OCC_W'(occ_q - 1'b1) : occ_q;

	assign ctl.access = fire;
	assign ctl.evict  = fire && evict;
	assign ctl.dump   = dump_step;

	assign chain_key[MAX_ENTRIES] = '0;
	assign pref[0] = 1'b0;

	for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
		lct_cell #(
			.IDX   (g),
			.OCC_W (OCC_W)
		) u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.key      (s_axis_tdata),
			.occ      (occ_q),
			.top      (top_idx),
			.next_key (chain_key[g+1]),
			.pref_in  (pref[g]),
			.pref_out (pref[g+1]),
			.match    (match[g]),
			.key_out  (chain_key[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= lct_pkg::CAP_RESET;
		end else if (cfg_wr_en) begin
			cap_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			occ_q       <= '0;
			out_valid_q <= 1'b0;
			out_kind_q  <= lct_pkg::KIND_STATUS;
			out_hit_q   <= 1'b0;
			out_ev_q    <= 1'b0;
			out_evkey_q <= '0;
			out_entry_q <= '0;
			out_last_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (fire) begin
						out_valid_q <= 1'b1;
						out_kind_q  <= lct_pkg::KIND_STATUS;
						out_hit_q   <= hit;
						out_ev_q    <= evict;
						out_evkey_q <= evict ? chain_key[0] : '0;
						out_entry_q <= '0;
						out_last_q  <= !s_axis_tlast;
						if (!hit && !evict) begin
							occ_q <= OCC_W'(occ_q + 1'b1);
						end
						if (s_axis_tlast) begin
							state_q <= ST_DUMP;
						end
					end else if (m_axis_tready) begin
						out_valid_q <= 1'b0;
					end
				end
				ST_DUMP: begin
					if (dump_step) begin
						out_valid_q <= 1'b1;
						out_kind_q  <= lct_pkg::KIND_ENTRY;
						out_hit_q   <= 1'b0;
						out_ev_q    <= 1'b0;
						out_evkey_q <= '0;
						out_entry_q <= chain_key[0];
						out_last_q  <= (occ_q == OCC_W'(1));
						occ_q       <= OCC_W'(occ_q - 1'b1);
						if (occ_q == OCC_W'(1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_kind_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = {6'b0, out_entry_q, out_evkey_q, out_ev_q, out_hit_q};

	// Stored keys are unique, so no more than one live cell can match.
	a_single_match: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(match))
		else $error("more than one cell matched the access key");

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OCC_W'(MAX_ENTRIES))
		else $error("occupancy exceeds the number of cells");

	a_dump_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DUMP) |-> (occ_q != '0))
		else $error("dump running with an empty store");

	a_eos_starts_dump: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && s_axis_tlast) |=> (state_q == ST_DUMP) && m_axis_tvalid)
		else $error("end of sequence did not start the dump");

	a_status_after_access: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> (m_axis_tuser == lct_pkg::KIND_STATUS) && (occ_q != '0))
		else $error("access did not leave a status transfer and a stored key");

endmodule

[dv/lru_cache_tracker_tb.sv]
`timescale 1ns / 100ps

module lru_cache_tracker_tb;

	localparam int MAX_KEYS     = lct_pkg::MAX_ENTRIES_DEF;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_CYCLES  = 300;

	typedef struct packed {
		logic        kind;
		logic        hit;
		logic        evicted;
		logic [31:0] evicted_key;
		logic [31:0] entry_key;
		logic        last;
	} lru_result_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      cfg_wr_en = 1'b0;
	logic [lct_pkg::CAP_W-1:0] cfg_wr_data = '0;
	logic                      s_axis_tvalid = 1'b0;
	logic                      s_axis_tready;
	logic [31:0]               s_axis_tdata = '0;    // key
	logic                      s_axis_tlast = 1'b0;  // end_of_sequence
	logic                      m_axis_tvalid;
	logic                      m_axis_tready = 1'b0;
	// hit [0], evicted_valid [1], evicted_key [33:2], entry_key [65:34], zero pad
	logic [71:0]               m_axis_tdata;
	logic                      m_axis_tuser;         // kind
	logic                      m_axis_tlast;         // last

	// Predictor state: slot 0 holds the least recent key.
	logic [31:0]               lru_keys [MAX_KEYS];
	int                        lru_count = 0;
	logic [lct_pkg::CAP_W-1:0] capacity_q = lct_pkg::CAP_RESET;

	lru_result_t       pending_results [$];

	bit                tx_idle = 1'b0;
	bit                rx_idle = 1'b0;
	int                rx_wait = 0;
	int                rx_hold = 0;

	int                mismatches = 0;
	int                n_access = 0;
	int                n_results = 0;
	int                n_dumps = 0;
	int                n_hits = 0;
	int                n_evicts = 0;

	lru_cache_tracker uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #6 clk = ~clk;

	function automatic void predict_access(logic [31:0] key, logic eos);
		int          eff;
		int          pos;
		logic        hit;
		logic        ev;
		logic [31:0] ev_key;
		lru_result_t r;
		eff = capacity_q;
		if (eff == 0) eff = 1;
		if (eff > MAX_KEYS) eff = MAX_KEYS;
		hit = 1'b0;
		ev = 1'b0;
		ev_key = '0;
		pos = 0;
		n_access++;
		for (int i = 0; i < lru_count; i++) begin
			if (!hit && lru_keys[i] == key) begin
				hit = 1'b1;
				pos = i;
			end
		end
		if (hit) begin
			for (int i = pos; i < lru_count - 1; i++) lru_keys[i] = lru_keys[i + 1];
			lru_keys[lru_count - 1] = key;
			n_hits++;
		end else if (lru_count >= eff) begin
			// The store stays at its occupancy even when capacity was lowered below it.
			ev = 1'b1;
			ev_key = lru_keys[0];
			for (int i = 0; i < lru_count - 1; i++) lru_keys[i] = lru_keys[i + 1];
			lru_keys[lru_count - 1] = key;
			n_evicts++;
		end else begin
			lru_keys[lru_count] = key;
			lru_count++;
		end
		r.kind = lct_pkg::KIND_STATUS;
		r.hit = hit;
		r.evicted = ev;
		r.evicted_key = ev_key;
		r.entry_key = '0;
		r.last = !eos;
		pending_results.push_back(r);
		if (eos) begin
			for (int i = 0; i < lru_count; i++) begin
				r.kind = lct_pkg::KIND_ENTRY;
				r.hit = 1'b0;
				r.evicted = 1'b0;
				r.evicted_key = '0;
				r.entry_key = lru_keys[i];
				r.last = (i == lru_count - 1);
				pending_results.push_back(r);
			end
			lru_count = 0;
			n_dumps++;
		end
	endfunction

	function automatic void check_result();
		lru_result_t want;
		n_results++;
		if (pending_results.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: unexpected result tuser=%b tdata=%h tlast=%b",
					$realtime, m_axis_tuser, m_axis_tdata, m_axis_tlast);
			return;
		end
		want = pending_results.pop_front();
		if (m_axis_tuser !== want.kind || m_axis_tdata[0] !== want.hit ||
		    m_axis_tdata[1] !== want.evicted || m_axis_tdata[33:2] !== want.evicted_key ||
		    m_axis_tdata[65:34] !== want.entry_key || m_axis_tlast !== want.last) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("%0t: mismatch expected kind=%b hit=%b ev=%b ev_key=%h entry=%h last=%b",
					$realtime, want.kind, want.hit, want.evicted, want.evicted_key,
					want.entry_key, want.last);
				$display("%0t:            actual kind=%b hit=%b ev=%b ev_key=%h entry=%h last=%b",
					$realtime, m_axis_tuser, m_axis_tdata[0], m_axis_tdata[1],
					m_axis_tdata[33:2], m_axis_tdata[65:34], m_axis_tlast);
			end
		end
	endfunction

	// Prediction and checking share one process so that an input transfer is always
	// predicted before any result in the same cycle is compared.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) predict_access(s_axis_tdata, s_axis_tlast);
			if (m_axis_tvalid && m_axis_tready) begin
				check_result();
				rx_wait = rx_idle ? $urandom_range(0, 15) : 0;
			end
			if (cfg_wr_en) capacity_q = cfg_wr_data;
		end
	end

	// Receiver: a long hold-off takes priority over the per-result wait.
	always @(negedge clk) begin
		if (rx_hold > 0) begin
			m_axis_tready <= 1'b0;
			rx_hold--;
		end else if (rx_wait > 0) begin
			m_axis_tready <= 1'b0;
			rx_wait--;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("lru_cache_tracker_tb: FAIL");
		$finish;
	end

	task automatic send_access(logic [31:0] key, logic eos);
		int gap;
		gap = tx_idle ? $urandom_range(0, 15) : 0;
		@(negedge clk);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= key;
		s_axis_tlast <= eos;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	task automatic stop_sending();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
	endtask

	// Sender pause: wait for every predicted result, then let the block settle.
	task automatic drain();
		stop_sending();
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_capacity(logic [lct_pkg::CAP_W-1:0] value);
		drain();
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Reset capacity, key extremes, a hit on the oldest key and a dump.
	task automatic test_key_extremes();
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		send_access(32'h8000_0000, 1'b0);
		send_access(32'h7FFF_FFFF, 1'b0);
		send_access(32'h0000_0000, 1'b0);
		send_access(32'hFFFF_FFFF, 1'b0);
		send_access(32'h8000_0000, 1'b0);
		send_access(32'h0000_0000, 1'b1);
	endtask

	// Capacity one, and zero which acts as one.
	task automatic test_tiny_capacity();
		set_capacity(5'd1);
		send_access(32'hA5A5_0001, 1'b0);
		send_access(32'h5A5A_0002, 1'b0);
		send_access(32'h5A5A_0002, 1'b1);
		set_capacity(5'd0);
		send_access(32'h0000_0011, 1'b0);
		send_access(32'h0000_0022, 1'b0);
		send_access(32'h0000_0033, 1'b1);
	endtask

	// Capacity lowered below the occupancy: misses evict one key and keep the count.
	task automatic test_capacity_shrink();
		set_capacity(5'd4);
		send_access(32'h1000_0001, 1'b0);
		send_access(32'h1000_0002, 1'b0);
		send_access(32'h1000_0003, 1'b0);
		send_access(32'h1000_0004, 1'b0);
		set_capacity(5'd2);
		send_access(32'h1000_0005, 1'b0);
		send_access(32'h1000_0003, 1'b0);
		send_access(32'h1000_0006, 1'b1);
	endtask

	// Receiver holds off while one miss more than a full store's worth arrives back to back;
	// capacity above the chain length saturates, so the last miss evicts.
	task automatic test_backpressure();
		set_capacity(5'd31);
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		rx_hold = HOLD_CYCLES;
		for (int i = 0; i <= MAX_KEYS; i++)
			send_access(($urandom & 32'hFFFF_FFE0) | i, i == MAX_KEYS);
		drain();
	endtask

	task automatic test_random_traffic();
		int          caps [7];
		int          eff;
		int          pool_size;
		logic [31:0] pool [$];
		logic [31:0] key;
		caps = '{2, 16, 1, 31, 5, 8, 0};
		caps[6] = $urandom_range(1, 16);
		for (int p = 0; p < 7; p++) begin
			set_capacity(lct_pkg::CAP_W'(caps[p]));
			tx_idle = (p % 3 != 0);
			rx_idle = (p % 2 != 0);
			eff = (caps[p] > MAX_KEYS) ? MAX_KEYS : caps[p];
			pool_size = eff + 3;
			pool.delete();
			for (int i = 0; i < pool_size; i++) pool.push_back($urandom);
			for (int n = 0; n < 52; n++) begin
				// Mostly keys from a small pool so hits and evictions mix; some noise.
				if ($urandom_range(0, 99) < 85) key = pool[$urandom_range(0, pool_size - 1)];
				else key = $urandom;
				send_access(key, $urandom_range(0, 11) == 0);
				if ($urandom_range(0, 49) == 0) drain();
			end
		end
	endtask

	initial begin
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		test_key_extremes();
		test_tiny_capacity();
		test_capacity_shrink();
		test_backpressure();
		test_random_traffic();
		drain();
		repeat (20) @(posedge clk);
		if (pending_results.size() != 0) begin
			$display("%0d expected results never arrived", pending_results.size());
			mismatches += pending_results.size();
		end
		$display("Covered %0d accesses and %0d results: %0d hits, %0d evictions, %0d dumps.",
			n_access, n_results, n_hits, n_evicts, n_dumps);
		$display("Capacities 0, 1, 2, 4, 5, 8, 16 and 31 were used, with a long output stall.");
		if (mismatches == 0) begin
			$display("lru_cache_tracker_tb: PASS");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("lru_cache_tracker_tb: FAIL");
		end
		$finish;
	end

endmodule
